/* hdl/f2da_pkg.sv */
package f2da_pkg;

  // field widths
  localparam int unsigned FLOAT_W = 32;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned CFG_W   = 4;

  // parameter defaults
  localparam int unsigned FRACTION_BITS_DEF       = 32;
  localparam int unsigned MAX_FRACTION_DIGITS_DEF = 8;

  localparam logic [CFG_W-1:0] FRAC_DIGITS_RESET = 4'd2;

  // ascii codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 7'h2E;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

  // integer part and binary to bcd conversion
  localparam int unsigned INT_W          = 31;
  localparam logic [INT_W-1:0] INT_SAT   = 31'h7FFF_FFFF;
  localparam int unsigned BIN_W          = 32;
  localparam int unsigned DEC_DIGITS     = 10;
  localparam int unsigned BCD_W          = 4 * DEC_DIGITS;
  localparam int unsigned BITS_PER_STEP  = 4;
  localparam int unsigned DABBLE_STEPS   = BIN_W / BITS_PER_STEP;
  localparam int unsigned STEP_CNT_W     = $clog2(DABBLE_STEPS);
  localparam int unsigned DIG_IDX_W      = $clog2(DEC_DIGITS);

  typedef enum logic [1:0] {
    CH_MINUS,
    CH_INT,
    CH_POINT,
    CH_FRAC
  } chsel_e;

  typedef struct packed {
    logic                 load;
    logic                 step;
    logic                 emit;
    chsel_e               sel;
    logic                 last;
    logic [DIG_IDX_W-1:0] int_idx;
  } cmd_t;

  typedef struct packed {
    logic                 neg;
    logic [DIG_IDX_W-1:0] int_digits;
  } stat_t;

endpackage

/* hdl/f2da_in_if.sv */
interface f2da_in_if;
  logic                         valid;
  logic                         ready;
  logic [f2da_pkg::FLOAT_W-1:0] float_bits;

  modport source (output valid, output float_bits, input ready);
  modport sink   (input valid, input float_bits, output ready);
endinterface

/* hdl/f2da_out_if.sv */
interface f2da_out_if;
  logic                        valid;
  logic                        ready;
  logic [f2da_pkg::CHAR_W-1:0] character;
  logic                        last_char;
  logic                        overflow;

  modport source (output valid, output character, output last_char, output overflow,
                  input ready);
  modport sink   (input valid, input character, input last_char, input overflow,
                  output ready);
endinterface

/* hdl/float_to_decimal_ascii.sv */
// float to decimal text: takes one ieee-754 single precision word per request on float_i
// and sends its fixed point decimal text on char_o, one ascii character per request: an
// optional '-', the integer digits most significant first, '.', then fraction_digits
// truncated fraction digits (written on cfg_we_i/cfg_data_i, reset 2, capped at
// MAX_FRACTION_DIGITS); the final character has last_char set, and overflow marks every
// character of a value of magnitude 2^31 or more, infinity or nan, whose integer part
// reads 2147483647. one value is converted at a time: an accepted request is loaded, then
// converted from binary to bcd four bits per cycle, then passes the sign state and emits
// its characters in order, each one waiting while char_o stalls. the next request is
// taken while the last character still waits in the output register.
module float_to_decimal_ascii #(
  parameter int unsigned FRACTION_BITS       = f2da_pkg::FRACTION_BITS_DEF,
  parameter int unsigned MAX_FRACTION_DIGITS = f2da_pkg::MAX_FRACTION_DIGITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [f2da_pkg::CFG_W-1:0] cfg_data_i,
  f2da_in_if.sink                    float_i,
  f2da_out_if.source                 char_o
);

  // command and status between sequencer and datapath
  f2da_pkg::cmd_t  cmd;
  f2da_pkg::stat_t stat;

  // sequencer: handshakes, conversion steps and character order
  f2da_ctrl #(
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (float_i.valid),
    .in_ready_o  (float_i.ready),
    .out_valid_o (char_o.valid),
    .out_ready_i (char_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: float to fixed point, bcd digits, fraction times ten, output register
  f2da_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .float_bits_i (float_i.float_bits),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .character_o  (char_o.character),
    .last_char_o  (char_o.last_char),
    .overflow_o   (char_o.overflow)
  );

endmodule

/* hdl/f2da_datapath.sv */
module f2da_datapath #(
  parameter int unsigned FRACTION_BITS = f2da_pkg::FRACTION_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic [f2da_pkg::FLOAT_W-1:0] float_bits_i,
  input  f2da_pkg::cmd_t               cmd_i,
  output f2da_pkg::stat_t              stat_o,
  output logic [f2da_pkg::CHAR_W-1:0]  character_o,
  output logic                         last_char_o,
  output logic                         overflow_o
);

  // mantissa placed by exponent: lsb weight 2^-149
  localparam int unsigned SHW = 24 + 156;
  localparam int unsigned FIX_POINT = 149;

  logic [7:0]                     ex;
  logic [22:0]                    man;
  logic [23:0]                    mant;
  logic [7:0]                     sh_amt;
  logic [SHW-1:0]                 placed;
  logic                           ovf_in;
  logic                           neg_in;

  logic                           neg_q, ovf_q;
  logic [f2da_pkg::BIN_W-1:0]     bin_q, bin_d;
  logic [f2da_pkg::BCD_W-1:0]     bcd_q, bcd_d;
  logic [FRACTION_BITS-1:0]       frac_q, frac_d;
  logic [FRACTION_BITS+3:0]       frac_x10;
  logic [3:0]                     frac_digit;
  logic [3:0]                     int_digit;
  logic [f2da_pkg::CHAR_W-1:0]    char_d, char_q;
  logic                           last_q;
  logic                           char_ovf_q;

  assign ex     = float_bits_i[30:23];
  assign man    = float_bits_i[22:0];
  assign mant   = (ex == 8'd0) ? {1'b0, man} : {1'b1, man};
  assign sh_amt = (ex == 8'd0) ? 8'd0 : ex - 8'd1;
  assign placed = {{(SHW-24){1'b0}}, mant} << sh_amt;
  assign ovf_in = (ex >= 8'd158);
  assign neg_in = float_bits_i[31] && !((ex == 8'hFF) && (man != 23'd0)) && (mant != 24'd0);

  // four double dabble steps per cycle
  always_comb begin
    logic [f2da_pkg::BCD_W-1:0] bcd_v;
    logic [f2da_pkg::BIN_W-1:0] bin_v;
    bcd_v = bcd_q;
    bin_v = bin_q;
    for (int s = 0; s < f2da_pkg::BITS_PER_STEP; s++) begin
      for (int d = 0; d < f2da_pkg::DEC_DIGITS; d++) begin
        if (bcd_v[d*4 +: 4] >= 4'd5) begin
          bcd_v[d*4 +: 4] = bcd_v[d*4 +: 4] + 4'd3;
        end
      end
      {bcd_v, bin_v} = {bcd_v[f2da_pkg::BCD_W-2:0], bin_v, 1'b0};
    end
    bcd_d = bcd_v;
    bin_d = bin_v;
  end

  // times ten as shift and add
  assign frac_x10   = ({4'd0, frac_q} << 3) + ({4'd0, frac_q} << 1);
  assign frac_digit = frac_x10[FRACTION_BITS+3:FRACTION_BITS];
  assign frac_d     = frac_x10[FRACTION_BITS-1:0];

  assign int_digit  = bcd_q[{cmd_i.int_idx, 2'b00} +: 4];

  // number of integer digits, at least one
  always_comb begin
    stat_o.neg        = neg_q;
    stat_o.int_digits = f2da_pkg::DIG_IDX_W'(1);
    for (int d = 1; d < f2da_pkg::DEC_DIGITS; d++) begin
      if (bcd_q[d*4 +: 4] != 4'd0) begin
        stat_o.int_digits = f2da_pkg::DIG_IDX_W'(d + 1);
      end
    end
  end

  always_comb begin
    case (cmd_i.sel)
      f2da_pkg::CH_MINUS: char_d = f2da_pkg::CHAR_MINUS;
      f2da_pkg::CH_POINT: char_d = f2da_pkg::CHAR_POINT;
      f2da_pkg::CH_INT:   char_d = f2da_pkg::CHAR_ZERO + {3'd0, int_digit};
      f2da_pkg::CH_FRAC:  char_d = f2da_pkg::CHAR_ZERO + {3'd0, frac_digit};
      default:            char_d = f2da_pkg::CHAR_ZERO;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q <= neg_in;
      ovf_q <= ovf_in;
      bcd_q <= '0;
      if (ovf_in) begin
        bin_q  <= {1'b0, f2da_pkg::INT_SAT};
        frac_q <= '0;
      end else begin
        bin_q  <= {1'b0, placed[FIX_POINT+f2da_pkg::INT_W-1:FIX_POINT]};
        frac_q <= placed[FIX_POINT-1 -: FRACTION_BITS];
      end
    end else if (cmd_i.step) begin
      bcd_q <= bcd_d;
      bin_q <= bin_d;
    end else if (cmd_i.emit && (cmd_i.sel == f2da_pkg::CH_FRAC)) begin
      frac_q <= frac_d;
    end
    // overflow travels with its character, a new load may follow
    if (cmd_i.emit) begin
      char_q     <= char_d;
      last_q     <= cmd_i.last;
      char_ovf_q <= ovf_q;
    end
  end

  assign character_o = char_q;
  assign last_char_o = last_q;
  assign overflow_o  = char_ovf_q;

endmodule

/* hdl/f2da_ctrl.sv */
module f2da_ctrl #(
  parameter int unsigned MAX_FRACTION_DIGITS = f2da_pkg::MAX_FRACTION_DIGITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [f2da_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  input  f2da_pkg::stat_t            stat_i,
  output f2da_pkg::cmd_t             cmd_o
);

  localparam int unsigned NDW = $clog2(MAX_FRACTION_DIGITS + 1);
  localparam int unsigned CW  = (NDW > f2da_pkg::CFG_W) ? NDW : f2da_pkg::CFG_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_INT,
    ST_POINT,
    ST_FRAC
  } state_e;

  state_e                            state_q, state_d;
  logic [f2da_pkg::STEP_CNT_W-1:0]   step_q, step_d;
  logic [f2da_pkg::DIG_IDX_W-1:0]    idx_q, idx_d;
  logic [NDW-1:0]                    fcnt_q, fcnt_d;
  logic                              valid_q, valid_d;
  logic [f2da_pkg::CFG_W-1:0]        cfg_q;
  logic [CW-1:0]                     cfg_ext, max_ext, nd_ext;
  logic [NDW-1:0]                    nd;
  logic                              slot_free;

  // digit count saturated to the maximum
  assign cfg_ext = CW'(cfg_q);
  assign max_ext = CW'(MAX_FRACTION_DIGITS);
  assign nd_ext  = (cfg_ext > max_ext) ? max_ext : cfg_ext;
  assign nd      = nd_ext[NDW-1:0];

  assign slot_free = !valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    idx_d         = idx_q;
    fcnt_d        = fcnt_q;
    cmd_o         = '0;
    cmd_o.sel     = f2da_pkg::CH_INT;
    cmd_o.int_idx = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.step = 1'b1;
        step_d     = step_q + 1'b1;
        if (step_q == f2da_pkg::STEP_CNT_W'(f2da_pkg::DABBLE_STEPS - 1)) begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN: begin
        idx_d = stat_i.int_digits - 1'b1;
        if (!stat_i.neg) begin
          state_d = ST_INT;
        end else if (slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = f2da_pkg::CH_MINUS;
          state_d    = ST_INT;
        end else begin
          idx_d = idx_q;
        end
      end
      ST_INT: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = f2da_pkg::CH_INT;
          if (idx_q == '0) begin
            state_d = ST_POINT;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      ST_POINT: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = f2da_pkg::CH_POINT;
          cmd_o.last = (nd == '0);
          fcnt_d     = '0;
          state_d    = (nd == '0) ? ST_IDLE : ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = f2da_pkg::CH_FRAC;
          cmd_o.last = (fcnt_q == nd - 1'b1);
          fcnt_d     = fcnt_q + 1'b1;
          if (fcnt_q == nd - 1'b1) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign valid_d = cmd_o.emit || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      idx_q   <= '0;
      fcnt_q  <= '0;
      valid_q <= 1'b0;
      cfg_q   <= f2da_pkg::FRAC_DIGITS_RESET;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      idx_q   <= idx_d;
      fcnt_q  <= fcnt_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = valid_q;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  // one character of the decimal text as it leaves the block
  typedef struct packed {
    logic [f2da_pkg::CHAR_W-1:0] ch;
    logic                        last;
    logic                        ovf;
  } text_char_t;

  // length of the long receiver hold-off that makes the block back up
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  // cycles allowed after draining, well above the per-value latency
  localparam int unsigned SETTLE_CYCLES    = 40;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [f2da_pkg::CFG_W-1:0] cfg_data_i;

  f2da_in_if  float_if ();
  f2da_out_if char_if ();

  float_to_decimal_ascii u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .float_i    (float_if),
    .char_o     (char_if)
  );

  always #5 clk_i = ~clk_i;

  // words still to be offered, and the text still owed by the block
  logic [f2da_pkg::FLOAT_W-1:0] float_backlog[$];
  text_char_t                   expected_text[$];

  // shadow of the fraction digit register
  logic [f2da_pkg::CFG_W-1:0] frac_digits_shadow;

  // idling knobs, in percent, set per phase
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // bumping burst_tag asks the receiver process for one long hold-off
  int unsigned burst_tag;
  int unsigned burst_seen;
  int unsigned hold_left;

  int unsigned mismatches;

  // works out the characters one word should give, appended to expected_text
  function automatic void format_value(input logic [f2da_pkg::FLOAT_W-1:0] bits,
                                       input logic [f2da_pkg::CFG_W-1:0] fd);
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [23:0] m;
    int          e;
    int          s;
    logic        ovf;
    logic        neg;
    logic [31:0] ipart;
    logic [63:0] frac;
    logic [67:0] prod;
    int          nd;
    int          nint;
    int          i;
    logic [3:0]  digs[f2da_pkg::DEC_DIGITS];
    text_char_t  line[$];

    sgn = bits[31];
    ex  = bits[30:23];
    man = bits[22:0];
    // denormals have no hidden one and share the exponent of the smallest normal
    if (ex == 8'd0) begin
      m = {1'b0, man};
      e = 1;
    end else begin
      m = {1'b1, man};
      e = ex;
    end
    // nan and zero never show a minus sign
    neg = sgn && (ex != 8'hFF || man == 23'd0) && (m != 24'd0);
    ovf = (ex == 8'hFF) || (e >= 158);

    ipart = '0;
    frac  = '0;
    if (ovf) begin
      ipart = {1'b0, f2da_pkg::INT_SAT};
    end else begin
      s = 150 - e;
      if (s <= 0) begin
        ipart = {8'd0, m} << (-s);
      end else begin
        ipart = (s >= 24) ? 32'd0 : ({8'd0, m} >> s);
        if (s <= 64)
          frac = {40'd0, m} << (64 - s);
        else if (s < 128)
          frac = {40'd0, m} >> (s - 64);
      end
      // keep only the fraction bits the block carries
      frac = frac & ~(64'hFFFF_FFFF_FFFF_FFFF >> f2da_pkg::FRACTION_BITS_DEF);
    end

    nint = 0;
    if (ipart == 32'd0) begin
      digs[0] = 4'd0;
      nint = 1;
    end
    while (ipart != 32'd0) begin
      digs[nint] = 4'(ipart % 10);
      ipart = ipart / 10;
      nint++;
    end

    if (neg)
      line.push_back('{f2da_pkg::CHAR_MINUS, 1'b0, ovf});
    for (i = nint - 1; i >= 0; i--)
      line.push_back('{f2da_pkg::CHAR_ZERO + 7'(digs[i]), 1'b0, ovf});
    line.push_back('{f2da_pkg::CHAR_POINT, 1'b0, ovf});

    nd = (fd > f2da_pkg::MAX_FRACTION_DIGITS_DEF) ? f2da_pkg::MAX_FRACTION_DIGITS_DEF : fd;
    for (i = 0; i < nd; i++) begin
      // times ten, the carry out of the fraction is the next digit
      prod = {4'd0, frac} * 68'd10;
      frac = prod[63:0];
      line.push_back('{f2da_pkg::CHAR_ZERO + 7'(prod[67:64]), 1'b0, ovf});
    end

    line[line.size() - 1].last = 1'b1;
    foreach (line[k])
      expected_text.push_back(line[k]);
  endfunction

  // random word, biased towards exponents that give readable digits
  function automatic logic [f2da_pkg::FLOAT_W-1:0] random_float();
    logic        sgn;
    logic [7:0]  ex;
    logic [22:0] man;

    sgn = 1'($urandom);
    man = 23'($urandom);
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2, 3, 4: ex = 8'($urandom_range(157, 110));
      5:       ex = 8'($urandom_range(157, 127));
      6:       ex = $urandom_range(1) ? 8'hFF : 8'h00;
      7:       ex = 8'($urandom_range(160, 150));
      8:       ex = 8'($urandom_range(126, 90));
      default: begin
        // zeros and infinities, either sign
        ex  = $urandom_range(1) ? 8'hFF : 8'h00;
        man = '0;
      end
    endcase
    return {sgn, ex, man};
  endfunction

  // sender: offers the head of the backlog, holds it until the request is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      float_if.valid      <= 1'b0;
      float_if.float_bits <= '0;
    end else begin
      if (float_if.valid && float_if.ready) begin
        format_value(float_if.float_bits, frac_digits_shadow);
        void'(float_backlog.pop_front());
      end
      if (!float_if.valid || float_if.ready) begin
        if (float_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          float_if.valid      <= 1'b1;
          float_if.float_bits <= float_backlog[0];
        end else begin
          float_if.valid      <= 1'b0;
          float_if.float_bits <= $urandom;
        end
      end
    end
  end

  // receiver ready: random stalls, plus one long hold-off when asked
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_if.ready <= 1'b0;
      hold_left     <= 0;
      burst_seen    <= 0;
    end else if (burst_seen != burst_tag) begin
      burst_seen    <= burst_tag;
      hold_left     <= LONG_HOLD_CYCLES;
      char_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      char_if.ready <= 1'b0;
    end else begin
      char_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // checker: every accepted character against the oldest one owed
  always @(posedge clk_i) begin : check_chars
    text_char_t got;
    text_char_t want;
    if (rst_ni && char_if.valid && char_if.ready) begin
      got = '{char_if.character, char_if.last_char, char_if.overflow};
      if (expected_text.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected char %h last %b ovf %b", got.ch, got.last, got.ovf);
      end else begin
        want = expected_text.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("char exp %h act %h, last exp %b act %b, ovf exp %b act %b",
                     want.ch, got.ch, want.last, got.last, want.ovf, got.ovf);
        end
      end
    end
  end

  // waits until every word is taken and all its text has come out
  task automatic wait_drained();
    while (float_backlog.size() != 0 || float_if.valid || expected_text.size() != 0)
      @(posedge clk_i);
  endtask

  // one phase: optional register write while idle, idling mode, random words
  task automatic run_phase(input bit do_write, input logic [f2da_pkg::CFG_W-1:0] fd,
                           input int n_items, input int unsigned send_pct,
                           input int unsigned recv_pct, input bit long_hold);
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (do_write) begin
      cfg_we_i   <= 1'b1;
      cfg_data_i <= fd;
      frac_digits_shadow = fd;
      @(posedge clk_i);
      cfg_we_i   <= 1'b0;
      cfg_data_i <= 4'($urandom);
    end
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (long_hold)
      burst_tag++;
    repeat (n_items)
      float_backlog.push_back(random_float());
    wait_drained();
  endtask

  initial begin
    cfg_we_i            = 1'b0;
    cfg_data_i          = '0;
    float_if.valid      = 1'b0;
    float_if.float_bits = '0;
    char_if.ready       = 1'b0;
    rst_ni              = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    burst_tag           = 0;
    mismatches          = 0;
    frac_digits_shadow  = f2da_pkg::FRAC_DIGITS_RESET;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words at the reset setting of two fraction digits
    float_backlog.push_back(32'h0000_0000);  // zero
    float_backlog.push_back(32'h8000_0000);  // negative zero, no sign shown
    float_backlog.push_back(32'h3F80_0000);  // one
    float_backlog.push_back(32'hBF80_0000);  // minus one
    float_backlog.push_back(32'h3F00_0000);  // one half
    float_backlog.push_back(32'h3DCC_CCCD);  // a tenth, truncated
    float_backlog.push_back(32'hBB83_126F);  // tiny negative prints minus and zeros
    float_backlog.push_back(32'h8000_0001);  // smallest negative denormal
    float_backlog.push_back(32'h0000_0001);  // smallest denormal
    float_backlog.push_back(32'h007F_FFFF);  // largest denormal
    float_backlog.push_back(32'h0080_0000);  // smallest normal
    float_backlog.push_back(32'h7F7F_FFFF);  // largest finite, saturates
    float_backlog.push_back(32'h7F80_0000);  // infinity
    float_backlog.push_back(32'hFF80_0000);  // negative infinity keeps its sign
    float_backlog.push_back(32'h7FC0_0000);  // nan
    float_backlog.push_back(32'hFFC0_0000);  // negative nan, no sign shown
    float_backlog.push_back(32'hFFFF_FFFF);  // all ones
    float_backlog.push_back(32'h4F00_0000);  // two to the 31, first saturating
    float_backlog.push_back(32'h4EFF_FFFF);  // largest below saturation
    float_backlog.push_back(32'hCEFF_FFFF);  // and its negative
    float_backlog.push_back(32'h4B00_0000);  // two to the 23
    float_backlog.push_back(32'h4B7F_FFFF);  // all mantissa bits integer
    float_backlog.push_back(32'h42F6_E979);  // ordinary mixed value
    float_backlog.push_back(32'h2F80_0000);  // weight of the lowest fraction bit
    float_backlog.push_back(32'h3F7F_FFFF);  // just below one
    wait_drained();

    // random phases over several register settings and idling modes
    run_phase(1'b1, 4'd0,  100, 0,  0,  1'b0);  // no fraction digits, no idling
    run_phase(1'b1, 4'd15, 70,  87, 0,  1'b0);  // saturating setting, sparse sender
    run_phase(1'b1, 4'd8,  70,  0,  87, 1'b0);  // most digits, stalling receiver
    run_phase(1'b1, 4'($urandom), 70, 13, 13, 1'b0);
    run_phase(1'b1, 4'd10, 40,  0,  13, 1'b1);  // long hold-off, block backs up
    run_phase(1'b1, 4'd5,  60,  13, 13, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_text.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
